>>> design/tmtr_pkg.sv
package tmtr_pkg;

   localparam int MAX_TAG_LEN_DEF = 256;
   localparam int CHAR_WIDTH_DEF  = 16;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_UPPER_I = 8'h49;
   localparam logic [7:0] CH_UPPER_B = 8'h42;
   localparam logic [7:0] CH_LOWER_P = 8'h70;
   localparam logic [7:0] CH_LOWER_S = 8'h73;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_W = 8'h77;
   localparam logic [7:0] CH_LOWER_C = 8'h63;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;

   typedef enum logic [2:0] {
      KIND_NUMREF   = 3'd0,
      KIND_SCRIPT   = 3'd1,
      KIND_COLOR    = 3'd2,
      KIND_POSITION = 3'd3,
      KIND_FONT     = 3'd4,
      KIND_SPEED    = 3'd5,
      KIND_WAIT     = 3'd6,
      KIND_CLEAR    = 3'd7
   } kind_type;

   typedef enum logic [6:0] {
      PH_IDLE   = 7'b0000001,
      PH_FIRST  = 7'b0000010,
      PH_AMP    = 7'b0000100,
      PH_LT     = 7'b0001000,
      PH_NUM    = 7'b0010000,
      PH_SCRIPT = 7'b0100000,
      PH_VALUES = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic            matched;
      logic [2:0]      tag_kind;
      logic [8:0]      tag_length;
      logic [2:0][7:0] value_offset;
      logic [2:0][7:0] value_length;
      logic [31:0]     main_color;
      logic [31:0]     edge_color;
   } result_type;

endpackage

>>> design/text_markup_tag_recognizer.sv
// Markup tag recognizer: takes one text character per cycle while req_ready is high and gives
// one result when a candidate tag (opened by req_tag_start) is accepted or rejected. Each
// character is decided combinationally by the scan logic, so req_ready stays high at one
// transfer per cycle as long as results are taken; the closing character's result is registered
// into a two-entry output buffer (output register plus skid register) that lets input keep
// flowing while one result waits; req_ready drops only when both hold a result.
module text_markup_tag_recognizer #(
   parameter int MAX_TAG_LEN = tmtr_pkg::MAX_TAG_LEN_DEF,
   parameter int CHAR_WIDTH  = tmtr_pkg::CHAR_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAR_WIDTH-1:0] req_text_char,
   input  logic                  req_tag_start,
   input  logic                  req_end_of_text,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_matched,
   output logic [2:0]            rsp_tag_kind,
   output logic [8:0]            rsp_tag_length,
   output logic [7:0]            rsp_first_value_offset,
   output logic [7:0]            rsp_first_value_length,
   output logic [7:0]            rsp_second_value_offset,
   output logic [7:0]            rsp_second_value_length,
   output logic [7:0]            rsp_third_value_offset,
   output logic [7:0]            rsp_third_value_length,
   output logic [31:0]           rsp_main_color,
   output logic [31:0]           rsp_edge_color
);

   localparam int OFF_W = $clog2(MAX_TAG_LEN + 1);
   localparam int SUM_W = ((OFF_W > 9) ? OFF_W : 9) + 1;
   localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_TAG_LEN);

   function automatic logic [CHAR_WIDTH-1:0] to_char(input logic [7:0] a);
      return CHAR_WIDTH'(a);
   endfunction

   // scan state
   tmtr_pkg::phase_type phase_ff, phase_in, cur_phase;
   tmtr_pkg::kind_type  kind_ff, kind_in;
   logic [1:0]          value_count_ff, value_count_in;
   logic                dot_seen_ff, dot_seen_in;
   logic                prev_question_ff, prev_question_in;
   logic [OFF_W-1:0]    char_offset_ff, char_offset_in;
   logic [OFF_W-1:0]    value_start_ff [3];
   logic [OFF_W-1:0]    value_start_in [3];
   logic [OFF_W-1:0]    value_length_ff [3];
   logic [OFF_W-1:0]    value_length_in [3];
   logic [23:0]         color_acc_ff [2];
   logic [23:0]         color_acc_in [2];

   // output buffer
   tmtr_pkg::result_type out_ff, out_in, skid_ff, skid_in, result;
   logic                 out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic                  take, clr, emit, fail, done, pop;
   logic [CHAR_WIDTH-1:0] c;
   logic                  is_num, is_hex, is_dot, dec_ok;
   logic [3:0]            hex_val;
   logic [OFF_W-1:0]      pos, sel_start, cur_len, l0, l1;
   logic [1:0]            t;

   assign c    = req_text_char;
   assign take = req_valid && req_ready;

   assign is_num = (c >= to_char(tmtr_pkg::CH_DIGIT_0)) && (c <= to_char(tmtr_pkg::CH_DIGIT_9));
   assign is_hex   = is_num
                  || ((c >= to_char(tmtr_pkg::CH_LOWER_A)) && (c <= to_char(tmtr_pkg::CH_LOWER_F)))
                  || ((c >= to_char(tmtr_pkg::CH_UPPER_A)) && (c <= to_char(tmtr_pkg::CH_UPPER_F)));
   // letters a-f and A-F both have low nibble 1..6
   assign hex_val  = is_num ? c[3:0] : 4'(c[3:0] + 4'd9);
   assign is_dot   = (c == to_char(tmtr_pkg::CH_DOT));

   always_comb begin
      clr = take && req_tag_start && !req_end_of_text;
      // a new candidate starts from a clean slate
      if (clr) begin
         kind_in          = tmtr_pkg::KIND_NUMREF;
         value_count_in   = '0;
         dot_seen_in      = 1'b0;
         prev_question_in = 1'b0;
         char_offset_in   = '0;
         value_start_in   = '{default: '0};
         value_length_in  = '{default: '0};
         color_acc_in     = '{default: '0};
      end else begin
         kind_in          = kind_ff;
         value_count_in   = value_count_ff;
         dot_seen_in      = dot_seen_ff;
         prev_question_in = prev_question_ff;
         char_offset_in   = char_offset_ff;
         value_start_in   = value_start_ff;
         value_length_in  = value_length_ff;
         color_acc_in     = color_acc_ff;
      end

      phase_in  = phase_ff;
      cur_phase = req_tag_start ? tmtr_pkg::PH_FIRST : phase_ff;
      pos       = char_offset_in;
      t         = value_count_in;
      sel_start = value_start_in[t];
      dec_ok    = is_num || (is_dot && !dot_seen_in);
      cur_len   = '0;
      l0        = '0;
      l1        = '0;
      fail      = 1'b0;
      done      = 1'b0;

      if (take) begin
         if (req_end_of_text) begin
            fail = (phase_ff != tmtr_pkg::PH_IDLE);
         end else if (req_tag_start || phase_ff != tmtr_pkg::PH_IDLE) begin
            if (pos >= MAX_OFF) begin
               fail = 1'b1;
            end else begin
               char_offset_in = pos + OFF_W'(1);
               unique case (cur_phase)
                  tmtr_pkg::PH_FIRST: begin
                     if (c == to_char(tmtr_pkg::CH_AMP)) phase_in = tmtr_pkg::PH_AMP;
                     else if (c == to_char(tmtr_pkg::CH_LT)) phase_in = tmtr_pkg::PH_LT;
                     else fail = 1'b1;
                  end
                  tmtr_pkg::PH_AMP: begin
                     if (c == to_char(tmtr_pkg::CH_HASH)) begin
                        kind_in  = tmtr_pkg::KIND_NUMREF;
                        phase_in = tmtr_pkg::PH_NUM;
                     end else begin
                        fail = 1'b1;
                     end
                  end
                  tmtr_pkg::PH_LT: begin
                     phase_in          = tmtr_pkg::PH_VALUES;
                     value_start_in[0] = OFF_W'(2);
                     if (c == to_char(tmtr_pkg::CH_HASH)) kind_in = tmtr_pkg::KIND_COLOR;
                     else if (c == to_char(tmtr_pkg::CH_LOWER_P)) kind_in = tmtr_pkg::KIND_POSITION;
                     else if (c == to_char(tmtr_pkg::CH_LOWER_S)) kind_in = tmtr_pkg::KIND_FONT;
                     else if (c == to_char(tmtr_pkg::CH_LOWER_R)) kind_in = tmtr_pkg::KIND_SPEED;
                     else if (c == to_char(tmtr_pkg::CH_LOWER_W)) kind_in = tmtr_pkg::KIND_WAIT;
                     else if (c == to_char(tmtr_pkg::CH_LOWER_C)) kind_in = tmtr_pkg::KIND_CLEAR;
                     else if (c == to_char(tmtr_pkg::CH_QUEST)) begin
                        kind_in           = tmtr_pkg::KIND_SCRIPT;
                        prev_question_in  = 1'b0;
                        value_start_in[0] = '0;
                        phase_in          = tmtr_pkg::PH_SCRIPT;
                     end else begin
                        fail = 1'b1;
                     end
                  end
                  tmtr_pkg::PH_NUM: begin
                     if (c == to_char(tmtr_pkg::CH_SEMI)) begin
                        value_start_in[0]  = OFF_W'(2);
                        value_length_in[0] = pos - OFF_W'(2);
                        done = 1'b1;
                     end else if (!is_num) begin
                        fail = 1'b1;
                     end
                  end
                  tmtr_pkg::PH_SCRIPT: begin
                     if (pos >= OFF_W'(3) && prev_question_in
                         && c == to_char(tmtr_pkg::CH_GT)) begin
                        value_start_in[0]  = OFF_W'(2);
                        value_length_in[0] = pos - OFF_W'(3);
                        done = 1'b1;
                     end else begin
                        prev_question_in = (c == to_char(tmtr_pkg::CH_QUEST));
                     end
                  end
                  tmtr_pkg::PH_VALUES: begin
                     if (t == 2'd3) begin
                        fail = 1'b1;
                     end else if (c == to_char(tmtr_pkg::CH_COMMA)) begin
                        if (t == 2'd2) begin
                           fail = 1'b1;
                        end else begin
                           value_length_in[t]          = pos - sel_start;
                           value_count_in              = 2'(t + 2'd1);
                           dot_seen_in                 = 1'b0;
                           value_start_in[2'(t + 2'd1)] = pos + OFF_W'(1);
                        end
                     end else if (c == to_char(tmtr_pkg::CH_LT)
                                  && !(kind_in == tmtr_pkg::KIND_FONT && t == 2'd1)) begin
                        fail = 1'b1;
                     end else if (c == to_char(tmtr_pkg::CH_GT)) begin
                        cur_len            = pos - sel_start;
                        value_length_in[t] = cur_len;
                        // an empty lone value counts as absent
                        if (t == 2'd0 && cur_len == '0) value_start_in[0] = '0;
                        l0 = value_length_in[0];
                        l1 = value_length_in[1];
                        if (kind_in == tmtr_pkg::KIND_COLOR
                            && (t == 2'd2
                                || (l0 != '0 && l0 != OFF_W'(6))
                                || (l1 != '0 && l1 != OFF_W'(6))
                                || (l0 == '0 && l1 == OFF_W'(6)))) begin
                           fail = 1'b1;
                        end else if (kind_in == tmtr_pkg::KIND_POSITION && t == 2'd0) begin
                           fail = 1'b1;
                        end else begin
                           done = 1'b1;
                        end
                     end else begin
                        case (kind_in)
                           tmtr_pkg::KIND_COLOR: begin
                              if (t > 2'd1 || !is_hex) fail = 1'b1;
                              else color_acc_in[t[0]] = {color_acc_in[t[0]][19:0], hex_val};
                           end
                           tmtr_pkg::KIND_POSITION: begin
                              if (c == to_char(tmtr_pkg::CH_PLUS)
                                  || c == to_char(tmtr_pkg::CH_MINUS)) begin
                                 // sign only as the first character of a value
                                 if (sel_start != pos) fail = 1'b1;
                              end else if (!dec_ok) begin
                                 fail = 1'b1;
                              end else if (is_dot) begin
                                 dot_seen_in = 1'b1;
                              end
                           end
                           tmtr_pkg::KIND_FONT: begin
                              if (t == 2'd0 && !is_num) fail = 1'b1;
                              else if (t == 2'd2 && c != to_char(tmtr_pkg::CH_UPPER_I)
                                       && c != to_char(tmtr_pkg::CH_UPPER_B)) fail = 1'b1;
                           end
                           tmtr_pkg::KIND_SPEED: begin
                              if (t != 2'd0 || !dec_ok) fail = 1'b1;
                              else if (is_dot) dot_seen_in = 1'b1;
                           end
                           default: begin
                              if (t != 2'd0) begin
                                 fail = 1'b1;
                              end else if (c == to_char(tmtr_pkg::CH_STAR)) begin
                                 if (sel_start != pos) fail = 1'b1;
                              end else if (!dec_ok) begin
                                 fail = 1'b1;
                              end else if (is_dot) begin
                                 dot_seen_in = 1'b1;
                              end
                           end
                        endcase
                     end
                  end
                  default: fail = 1'b1;
               endcase
            end
         end
      end

      emit = fail || done;
      if (emit) phase_in = tmtr_pkg::PH_IDLE;

      result = '0;
      if (done) begin
         result.matched    = 1'b1;
         result.tag_kind   = kind_in;
         result.tag_length = 9'(SUM_W'(pos) + SUM_W'(1));
         for (int i = 0; i < 3; i++) begin
            result.value_offset[i] = 8'(value_start_in[i]);
            result.value_length[i] = 8'(value_length_in[i]);
         end
         if (kind_in == tmtr_pkg::KIND_COLOR) begin
            if (value_length_in[0] != '0)
               result.main_color = {tmtr_pkg::ALPHA_OPAQUE, color_acc_in[0]};
            if (value_length_in[1] != '0)
               result.edge_color = {tmtr_pkg::ALPHA_OPAQUE, color_acc_in[1]};
         end
      end
   end

   // output register with skid stage
   assign req_ready = !skid_valid_ff;
   assign pop       = out_valid_ff && rsp_ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = emit;
         end
      end else if (emit) begin
         // hold the waiting result, park the new one
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tmtr_pkg::PH_IDLE;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff          <= kind_in;
      value_count_ff   <= value_count_in;
      dot_seen_ff      <= dot_seen_in;
      prev_question_ff <= prev_question_in;
      char_offset_ff   <= char_offset_in;
      value_start_ff   <= value_start_in;
      value_length_ff  <= value_length_in;
      color_acc_ff     <= color_acc_in;
      out_ff           <= out_in;
      skid_ff          <= skid_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_matched             = out_ff.matched;
   assign rsp_tag_kind            = out_ff.tag_kind;
   assign rsp_tag_length          = out_ff.tag_length;
   assign rsp_first_value_offset  = out_ff.value_offset[0];
   assign rsp_first_value_length  = out_ff.value_length[0];
   assign rsp_second_value_offset = out_ff.value_offset[1];
   assign rsp_second_value_length = out_ff.value_length[1];
   assign rsp_third_value_offset  = out_ff.value_offset[2];
   assign rsp_third_value_length  = out_ff.value_length[2];
   assign rsp_main_color          = out_ff.main_color;
   assign rsp_edge_color          = out_ff.edge_color;

endmodule

>>> tb/text_markup_tag_recognizer_tb.sv
module text_markup_tag_recognizer_tb;

   localparam int CYCLE_LIMIT = 400_000;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_text_char = '0;
   logic        req_tag_start = 1'b0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_matched;
   logic [2:0]  rsp_tag_kind;
   logic [8:0]  rsp_tag_length;
   logic [7:0]  rsp_first_value_offset;
   logic [7:0]  rsp_first_value_length;
   logic [7:0]  rsp_second_value_offset;
   logic [7:0]  rsp_second_value_length;
   logic [7:0]  rsp_third_value_offset;
   logic [7:0]  rsp_third_value_length;
   logic [31:0] rsp_main_color;
   logic [31:0] rsp_edge_color;

   text_markup_tag_recognizer dut (.*);

   // scanner state mirrored from the block
   tmtr_pkg::phase_type scan_state = tmtr_pkg::PH_IDLE;
   tmtr_pkg::kind_type  open_kind = tmtr_pkg::KIND_NUMREF;
   int          value_idx = 0;
   bit          dot_taken = 0;
   bit          last_was_question = 0;
   int          tag_pos = 0;
   int          value_start[3] = '{0, 0, 0};
   int          val_length[3] = '{0, 0, 0};
   logic [23:0] color_acc[2] = '{24'h0, 24'h0};

   tmtr_pkg::result_type expected_results[$];
   logic [15:0] tag_text[$];
   int          tag_items = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          hold_request = 0;
   int          hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [15:0] ch16(input logic [7:0] a);
      return {8'h00, a};
   endfunction

   function automatic bit is_num_char(input logic [15:0] ch);
      return ch >= ch16(tmtr_pkg::CH_DIGIT_0) && ch <= ch16(tmtr_pkg::CH_DIGIT_9);
   endfunction

   function automatic bit take_decimal(input logic [15:0] ch);
      if (is_num_char(ch)) return 1'b1;
      if (ch == ch16(tmtr_pkg::CH_DOT) && !dot_taken) begin
         dot_taken = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the mirrored scanner by one transfer; returns 1 when a result is due.
   function automatic bit predict_tag_result(input logic [15:0] ch, input logic start,
                                             input logic eot,
                                             output tmtr_pkg::result_type res);
      int         pos;
      int         t;
      int         len;
      bit         closed;
      bit         good;
      bit         hex_ok;
      logic [3:0] nib;
      res = '0;
      closed = 1'b0;
      good = 1'b0;
      len = 0;
      nib = '0;
      if (eot) begin
         closed = (scan_state != tmtr_pkg::PH_IDLE);
         scan_state = tmtr_pkg::PH_IDLE;
         return closed;
      end
      if (start) begin
         scan_state = tmtr_pkg::PH_FIRST;
         open_kind = tmtr_pkg::KIND_NUMREF;
         value_idx = 0;
         dot_taken = 1'b0;
         last_was_question = 1'b0;
         tag_pos = 0;
         value_start = '{0, 0, 0};
         val_length = '{0, 0, 0};
         color_acc = '{24'h0, 24'h0};
      end else if (scan_state == tmtr_pkg::PH_IDLE) begin
         return 1'b0;
      end
      pos = tag_pos;
      if (pos >= tmtr_pkg::MAX_TAG_LEN_DEF) begin
         scan_state = tmtr_pkg::PH_IDLE;
         return 1'b1;
      end
      tag_pos = pos + 1;
      t = value_idx;
      case (scan_state)
         tmtr_pkg::PH_FIRST: begin
            if (ch == ch16(tmtr_pkg::CH_AMP)) scan_state = tmtr_pkg::PH_AMP;
            else if (ch == ch16(tmtr_pkg::CH_LT)) scan_state = tmtr_pkg::PH_LT;
            else closed = 1'b1;
         end
         tmtr_pkg::PH_AMP: begin
            if (ch == ch16(tmtr_pkg::CH_HASH)) begin
               open_kind = tmtr_pkg::KIND_NUMREF;
               scan_state = tmtr_pkg::PH_NUM;
            end else begin
               closed = 1'b1;
            end
         end
         tmtr_pkg::PH_LT: begin
            case (ch)
               ch16(tmtr_pkg::CH_HASH):    open_kind = tmtr_pkg::KIND_COLOR;
               ch16(tmtr_pkg::CH_LOWER_P): open_kind = tmtr_pkg::KIND_POSITION;
               ch16(tmtr_pkg::CH_LOWER_S): open_kind = tmtr_pkg::KIND_FONT;
               ch16(tmtr_pkg::CH_LOWER_R): open_kind = tmtr_pkg::KIND_SPEED;
               ch16(tmtr_pkg::CH_LOWER_W): open_kind = tmtr_pkg::KIND_WAIT;
               ch16(tmtr_pkg::CH_LOWER_C): open_kind = tmtr_pkg::KIND_CLEAR;
               ch16(tmtr_pkg::CH_QUEST):   open_kind = tmtr_pkg::KIND_SCRIPT;
               default:                    closed = 1'b1;
            endcase
            if (!closed) begin
               value_start[0] = 2;
               last_was_question = 1'b0;
               if (open_kind == tmtr_pkg::KIND_SCRIPT) scan_state = tmtr_pkg::PH_SCRIPT;
               else scan_state = tmtr_pkg::PH_VALUES;
            end
         end
         tmtr_pkg::PH_NUM: begin
            if (ch == ch16(tmtr_pkg::CH_SEMI)) begin
               value_start[0] = 2;
               val_length[0] = pos - 2;
               closed = 1'b1;
               good = 1'b1;
               len = pos + 1;
            end else if (!is_num_char(ch)) begin
               closed = 1'b1;
            end
         end
         tmtr_pkg::PH_SCRIPT: begin
            if (pos >= 3 && last_was_question && ch == ch16(tmtr_pkg::CH_GT)) begin
               value_start[0] = 2;
               val_length[0] = pos - 3;
               closed = 1'b1;
               good = 1'b1;
               len = pos + 1;
            end else begin
               last_was_question = (ch == ch16(tmtr_pkg::CH_QUEST));
            end
         end
         tmtr_pkg::PH_VALUES: begin
            if (ch == ch16(tmtr_pkg::CH_COMMA)) begin
               val_length[t] = pos - value_start[t];
               if (t == 2) begin
                  closed = 1'b1;
               end else begin
                  value_idx = t + 1;
                  dot_taken = 1'b0;
                  value_start[t + 1] = pos + 1;
               end
            end else if (ch == ch16(tmtr_pkg::CH_LT)
                         && !(open_kind == tmtr_pkg::KIND_FONT && t == 1)) begin
               closed = 1'b1;
            end else if (ch == ch16(tmtr_pkg::CH_GT)) begin
               val_length[t] = pos - value_start[t];
               // an empty lone value counts as absent
               if (t == 0 && val_length[0] == 0) value_start[0] = 0;
               closed = 1'b1;
               good = 1'b1;
               len = pos + 1;
               if (open_kind == tmtr_pkg::KIND_COLOR &&
                   (t == 2 || (val_length[0] != 0 && val_length[0] != 6) ||
                    (val_length[1] != 0 && val_length[1] != 6) ||
                    (val_length[0] == 0 && val_length[1] == 6)))
                  good = 1'b0;
               if (open_kind == tmtr_pkg::KIND_POSITION && t == 0) good = 1'b0;
            end else begin
               case (open_kind)
                  tmtr_pkg::KIND_COLOR: begin
                     hex_ok = 1'b1;
                     if (is_num_char(ch))
                        nib = 4'(ch - ch16(tmtr_pkg::CH_DIGIT_0));
                     else if (ch >= ch16(tmtr_pkg::CH_LOWER_A) && ch <= ch16(tmtr_pkg::CH_LOWER_F))
                        nib = 4'(ch - ch16(tmtr_pkg::CH_LOWER_A) + 16'd10);
                     else if (ch >= ch16(tmtr_pkg::CH_UPPER_A) && ch <= ch16(tmtr_pkg::CH_UPPER_F))
                        nib = 4'(ch - ch16(tmtr_pkg::CH_UPPER_A) + 16'd10);
                     else
                        hex_ok = 1'b0;
                     if (t > 1 || !hex_ok) closed = 1'b1;
                     else color_acc[t] = {color_acc[t][19:0], nib};
                  end
                  tmtr_pkg::KIND_POSITION: begin
                     if (ch == ch16(tmtr_pkg::CH_PLUS) || ch == ch16(tmtr_pkg::CH_MINUS))
                        closed = (value_start[t] != pos);
                     else
                        closed = !take_decimal(ch);
                  end
                  tmtr_pkg::KIND_FONT: begin
                     closed = (t == 0 && !is_num_char(ch)) ||
                              (t == 2 && ch != ch16(tmtr_pkg::CH_UPPER_I)
                                      && ch != ch16(tmtr_pkg::CH_UPPER_B));
                  end
                  tmtr_pkg::KIND_SPEED: closed = (t != 0) || !take_decimal(ch);
                  default: begin
                     if (t != 0) closed = 1'b1;
                     else if (ch == ch16(tmtr_pkg::CH_STAR)) closed = (value_start[0] != pos);
                     else closed = !take_decimal(ch);
                  end
               endcase
            end
         end
         default: closed = 1'b1;
      endcase
      if (closed) begin
         scan_state = tmtr_pkg::PH_IDLE;
         if (good) begin
            res.matched = 1'b1;
            res.tag_kind = open_kind;
            res.tag_length = 9'(len);
            for (int i = 0; i < 3; i++) begin
               res.value_offset[i] = 8'(value_start[i]);
               res.value_length[i] = 8'(val_length[i]);
            end
            if (open_kind == tmtr_pkg::KIND_COLOR && val_length[0] != 0)
               res.main_color = {tmtr_pkg::ALPHA_OPAQUE, color_acc[0]};
            if (open_kind == tmtr_pkg::KIND_COLOR && val_length[1] != 0)
               res.edge_color = {tmtr_pkg::ALPHA_OPAQUE, color_acc[1]};
         end
      end
      return closed;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      tmtr_pkg::result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (predict_tag_result(req_text_char, req_tag_start, req_end_of_text, want))
               expected_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               check_field("results waiting", 32'd1, 32'd0);
            end else begin
               want = expected_results.pop_front();
               check_field("matched", 32'(want.matched), 32'(rsp_matched));
               check_field("tag_kind", 32'(want.tag_kind), 32'(rsp_tag_kind));
               check_field("tag_length", 32'(want.tag_length), 32'(rsp_tag_length));
               check_field("first_value_offset", 32'(want.value_offset[0]),
                           32'(rsp_first_value_offset));
               check_field("first_value_length", 32'(want.value_length[0]),
                           32'(rsp_first_value_length));
               check_field("second_value_offset", 32'(want.value_offset[1]),
                           32'(rsp_second_value_offset));
               check_field("second_value_length", 32'(want.value_length[1]),
                           32'(rsp_second_value_length));
               check_field("third_value_offset", 32'(want.value_offset[2]),
                           32'(rsp_third_value_offset));
               check_field("third_value_length", 32'(want.value_length[2]),
                           32'(rsp_third_value_length));
               check_field("main_color", want.main_color, rsp_main_color);
               check_field("edge_color", want.edge_color, rsp_edge_color);
            end
         end
      end
   end

   // receiver: random stalls, plus a counted hold-off on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request <= 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_char(input logic [15:0] ch, input logic start, input logic eot);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_char   <= ch;
      req_tag_start   <= start;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]}, i == 0, 1'b0);
   endtask

   function automatic logic [15:0] rand_char();
      if ($urandom_range(3) == 0) return 16'($urandom_range(16'hFFFF));
      return 16'($urandom_range(126, 32));
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) tag_text.push_back({8'h00, s[i]});
   endfunction

   function automatic void put_number(input int n, input bit dots);
      repeat (n) begin
         if (dots && $urandom_range(4) == 0) tag_text.push_back(ch16(tmtr_pkg::CH_DOT));
         else tag_text.push_back(ch16(tmtr_pkg::CH_DIGIT_0) + 16'($urandom_range(9)));
      end
   endfunction

   function automatic void put_hex(input int n);
      string hex_set = "0123456789abcdefABCDEF";
      repeat (n) tag_text.push_back({8'h00, hex_set[$urandom_range(21)]});
   endfunction

   // Mostly well-formed tags of every kind with random content.
   function automatic void build_random_tag();
      int n;
      tag_text.delete();
      case (tmtr_pkg::kind_type'($urandom_range(7)))
         tmtr_pkg::KIND_NUMREF: begin
            put_text("&#");
            put_number(($urandom_range(39) == 0) ? $urandom_range(256, 240) : $urandom_range(5),
                       1'b0);
            tag_text.push_back(ch16(tmtr_pkg::CH_SEMI));
         end
         tmtr_pkg::KIND_SCRIPT: begin
            put_text("<?");
            repeat ($urandom_range(8)) tag_text.push_back(rand_char());
            put_text("?>");
         end
         tmtr_pkg::KIND_COLOR: begin
            put_text("<#");
            put_hex(($urandom_range(3) == 0) ? $urandom_range(7) : 6);
            if ($urandom_range(2) != 0) begin
               tag_text.push_back(ch16(tmtr_pkg::CH_COMMA));
               put_hex(($urandom_range(3) == 0) ? $urandom_range(7) : 6);
            end
            if ($urandom_range(9) == 0) tag_text.push_back(ch16(tmtr_pkg::CH_COMMA));
            tag_text.push_back(ch16(tmtr_pkg::CH_GT));
         end
         tmtr_pkg::KIND_POSITION: begin
            put_text("<p");
            n = $urandom_range(3, 1);
            for (int i = 0; i < n; i++) begin
               if (i != 0) tag_text.push_back(ch16(tmtr_pkg::CH_COMMA));
               if ($urandom_range(2) == 0)
                  tag_text.push_back($urandom_range(1) ? ch16(tmtr_pkg::CH_PLUS)
                                                       : ch16(tmtr_pkg::CH_MINUS));
               put_number($urandom_range(4), 1'b1);
            end
            tag_text.push_back(ch16(tmtr_pkg::CH_GT));
         end
         tmtr_pkg::KIND_FONT: begin
            put_text("<s");
            put_number($urandom_range(3), 1'b0);
            if ($urandom_range(2) != 0) begin
               tag_text.push_back(ch16(tmtr_pkg::CH_COMMA));
               repeat ($urandom_range(5)) tag_text.push_back(rand_char());
               if ($urandom_range(1)) begin
                  tag_text.push_back(ch16(tmtr_pkg::CH_COMMA));
                  repeat ($urandom_range(2))
                     tag_text.push_back($urandom_range(1) ? ch16(tmtr_pkg::CH_UPPER_I)
                                                          : ch16(tmtr_pkg::CH_UPPER_B));
               end
            end
            tag_text.push_back(ch16(tmtr_pkg::CH_GT));
         end
         tmtr_pkg::KIND_SPEED: begin
            put_text("<r");
            put_number($urandom_range(4), 1'b1);
            if ($urandom_range(9) == 0) put_text(",1");
            tag_text.push_back(ch16(tmtr_pkg::CH_GT));
         end
         default: begin
            put_text($urandom_range(1) ? "<w" : "<c");
            if ($urandom_range(2) == 0) tag_text.push_back(ch16(tmtr_pkg::CH_STAR));
            put_number($urandom_range(4), 1'b1);
            tag_text.push_back(ch16(tmtr_pkg::CH_GT));
         end
      endcase
   endfunction

   // Send the built tag; when asked, corrupt it, cut it short or end the text.
   task automatic send_tag(input bit mutate);
      int cut;
      int roll;
      bit close_text;
      cut = tag_text.size();
      roll = mutate ? $urandom_range(99) : 99;
      close_text = 1'b0;
      if (roll < 8) begin
         tag_text[$urandom_range(cut - 1)] = rand_char();
      end else if (roll < 16) begin
         cut = $urandom_range(cut - 1);
         close_text = 1'b1;
      end else if (roll < 22) begin
         cut = $urandom_range(cut - 1);
      end else begin
         close_text = mutate && roll >= 95;
      end
      for (int i = 0; i < cut; i++) send_char(tag_text[i], i == 0, 1'b0);
      if (close_text) send_char(rand_char(), 1'b0, 1'b1);
      tag_items += cut + close_text;
   endtask

   task automatic test_directed_tags();
      send_text("&#65;");
      send_text("&#;");
      send_text("&#1x");
      send_text("&x");
      send_text("<?a?b?>");
      send_text("<??>");
      send_text("<#ff00AA,0088cc>");
      send_text("<#a1B2c3>");
      send_text("<#>");
      send_text("<#12345>");
      send_text("<#,00FF00>");
      send_text("<#123456,654321,>");
      send_text("<p+1.5,-2.,3>");
      send_text("<p7>");
      send_text("<p1,2+>");
      send_text("<s12,<Sans,IB>");
      send_text("<s,x,BX>");
      send_text("<r0.5>");
      send_text("<r1..2>");
      send_text("<w*1.5>");
      send_text("<w1*>");
      send_text("<c>");
      send_text("<c<");
      send_text("<z");
      // open tag dropped by a new start
      send_text("<p1");
      send_text("&#;");
      // end of text rejects the open tag, then finds nothing open
      send_text("<r12");
      send_char(16'hFFFF, 1'b0, 1'b1);
      send_char(16'h0000, 1'b0, 1'b1);
      // text outside a tag is dropped; candidates that open on a wrong character are rejected
      send_char(ch16(tmtr_pkg::CH_LT), 1'b0, 1'b0);
      send_char(16'hFFFF, 1'b1, 1'b0);
      send_char(16'h0000, 1'b1, 1'b0);
      send_char(16'h013C, 1'b1, 1'b0);
      send_text("&#");
      send_char(16'h5A5A, 1'b0, 1'b1);
      send_text("&#;");
      send_char(16'hA5A5, 1'b0, 1'b1);
   endtask

   task automatic test_tag_length_limits();
      // longest script that fits, then one that runs past the limit, whose tail must be ignored
      for (int extra = 0; extra < 2; extra++) begin
         tag_text.delete();
         put_text("<?");
         repeat (252 + 3 * extra) tag_text.push_back(ch16(tmtr_pkg::CH_LOWER_A));
         put_text("?>");
         send_tag(1'b0);
      end
   endtask

   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request <= 150;
      repeat (20) send_text("&#;");
   endtask

   task automatic test_random_text(input int idle_pct, input int stall_pct, input int goal);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      tag_items = 0;
      while (tag_items < goal) begin
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) send_char(rand_char(), 1'b0, 1'b0);
         build_random_tag();
         send_tag(1'b1);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_tags();
      test_tag_length_limits();
      test_output_backpressure();
      test_random_text(0, 0, 75);
      test_random_text(82, 0, 75);
      test_random_text(0, 82, 75);
      test_random_text(38, 38, 75);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/tmtr_pkg.sv
design/text_markup_tag_recognizer.sv
tb/text_markup_tag_recognizer_tb.sv
